[rtl/core/vertex_weld_table_unit_macros.svh]
// Assertion macros for the vertex weld table RTL
`ifndef VERTEX_WELD_TABLE_UNIT_MACROS_SVH
`define VERTEX_WELD_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define VWT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vertex weld table: assertion failed");
// Next-cycle implication, disabled during reset
`define VWT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vertex weld table: assertion failed");
`else
`define VWT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VWT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/vwt_pkg.sv]
package vwt_pkg;

  // Field widths
  localparam int COORD_W = 32;
  localparam int TOL_W   = 21;
  localparam int IDX_W   = 10;

  // Store depth default
  localparam int MAX_POINTS_DEF = 1024;

  // Register file
  localparam int                APB_AW    = 3;
  localparam int                APB_DW    = 32;
  localparam logic              REG_TOL   = 1'b0;  // word select paddr[2]
  localparam logic [TOL_W-1:0]  TOL_RESET = 21'd10;

  // One stored point
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // Memory port controls
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

[rtl/core/vertex_weld_table_unit.sv]
// One item at a time: in_stall is high from input transfer until the result moves to the
//   output register; one store entry is read per cycle through one port.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, synchronous): point count 0, tolerance 10, channels idle;
//   store contents stay undefined and are never read before written.
`include "vertex_weld_table_unit_macros.svh"

module vertex_weld_table_unit #(
  parameter int MAX_POINTS = vwt_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [vwt_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [vwt_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [vwt_pkg::COORD_W-1:0] in_coord_z,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [vwt_pkg::IDX_W-1:0]          out_point_index,
  output logic                               out_is_new,
  output logic                               out_table_full,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vwt_pkg::APB_AW-1:0]         paddr,
  input  logic [vwt_pkg::APB_DW-1:0]         pwdata,
  output logic [vwt_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import vwt_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [TOL_W-1:0] tol_r, tol_nxt;
  logic             tol_wr;
  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  point_t           mem_wdata;
  point_t           mem_rdata;
  point_t           probe;
  logic             hit;
  logic [CW-1:0]    point_count;

  // Tolerance register
  assign pready  = 1'b1;
  assign tol_wr  = psel && penable && pwrite && (paddr[2] == REG_TOL);
  assign tol_nxt = tol_wr ? pwdata[TOL_W-1:0] : tol_r;
  assign prdata  = (paddr[2] == REG_TOL) ? {{(APB_DW-TOL_W){1'b0}}, tol_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else begin
      tol_r <= tol_nxt;
    end
  end

  vwt_seq #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_index (out_point_index),
    .out_is_new      (out_is_new),
    .out_table_full  (out_table_full),
    .mem_ctl         (mem_ctl),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .probe           (probe),
    .hit             (hit),
    .point_count     (point_count)
  );

  vwt_store #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  vwt_cmp u_cmp (
    .probe  (probe),
    .stored (mem_rdata),
    .tol    (tol_r),
    .hit    (hit)
  );

  // Checks
  `VWT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `VWT_ASSERT_IMP(a_flags_exclusive, clk, rst_n, out_valid, !(out_is_new && out_table_full))
  `VWT_ASSERT_IMP(a_drop_only_when_full, clk, rst_n, out_valid && out_table_full,
                  point_count == CW'(MAX_POINTS) && out_point_index == '0)
  `VWT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, point_count <= CW'(MAX_POINTS))

endmodule

[rtl/core/vwt_store.sv]
module vwt_store #(
  parameter int MAX_POINTS = vwt_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic              clk,
  input  vwt_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     waddr,
  input  vwt_pkg::point_t   wdata,
  input  logic [AW-1:0]     raddr,
  output vwt_pkg::point_t   rdata
);
  import vwt_pkg::*;

  point_t mem [MAX_POINTS];
  point_t rdata_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/vwt_cmp.sv]
module vwt_cmp (
  input  vwt_pkg::point_t                 probe,
  input  vwt_pkg::point_t                 stored,
  input  logic [vwt_pkg::TOL_W-1:0]       tol,
  output logic                            hit
);
  import vwt_pkg::*;

  localparam int DW = COORD_W + 2;

  // Exact difference, strictly inside (-tol, tol)
  function automatic logic axis_near(logic signed [COORD_W-1:0] a,
                                     logic signed [COORD_W-1:0] b,
                                     logic [TOL_W-1:0] t);
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] lim;
    d   = $signed({{2{a[COORD_W-1]}}, a}) - $signed({{2{b[COORD_W-1]}}, b});
    lim = $signed({{(DW-TOL_W){1'b0}}, t});
    return (d < lim) && (d > -lim);
  endfunction

  assign hit = axis_near(probe.x, stored.x, tol) &&
               axis_near(probe.y, stored.y, tol) &&
               axis_near(probe.z, stored.z, tol);

endmodule

[rtl/core/vwt_seq.sv]
module vwt_seq #(
  parameter int MAX_POINTS = vwt_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS),
  parameter int CW         = $clog2(MAX_POINTS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [vwt_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [vwt_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [vwt_pkg::COORD_W-1:0] in_coord_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vwt_pkg::IDX_W-1:0]         out_point_index,
  output logic                              out_is_new,
  output logic                              out_table_full,
  // store and compare
  output vwt_pkg::mem_ctl_t                 mem_ctl,
  output logic [AW-1:0]                     mem_waddr,
  output vwt_pkg::point_t                   mem_wdata,
  output logic [AW-1:0]                     mem_raddr,
  output vwt_pkg::point_t                   probe,
  input  logic                              hit,
  // status
  output logic [CW-1:0]                     point_count
);
  import vwt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_POST = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      issue_r, issue_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]      pend_idx_r, pend_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  point_t             pt_r, pt_nxt;
  logic [IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic               res_new_r, res_new_nxt;
  logic               res_full_r, res_full_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic               out_new_r, out_new_nxt;
  logic               out_full_r, out_full_nxt;

  logic in_xfer;
  logic rd_en;
  logic match;
  logic miss_end;
  logic store_full;
  logic out_load;

  // Decode scan events
  assign in_xfer    = in_valid && (state_r == S_IDLE);
  assign store_full = (count_r == CW'(MAX_POINTS));
  assign rd_en      = (state_r == S_SCAN) && (issue_r < count_r);
  assign match      = (state_r == S_SCAN) && pend_vld_r && hit;
  assign miss_end   = (state_r == S_SCAN) && !pend_vld_r && (issue_r >= count_r);
  assign out_load   = (state_r == S_POST) && (!out_valid_r || !out_stall);

  // Memory ports: stream reads, append on a miss
  assign mem_ctl.re = rd_en;
  assign mem_ctl.we = miss_end && !store_full;
  assign mem_raddr  = issue_r[AW-1:0];
  assign mem_waddr  = count_r[AW-1:0];
  assign mem_wdata  = pt_r;
  assign probe      = pt_r;

  // Next state and control
  always_comb begin
    state_nxt    = state_r;
    issue_nxt    = issue_r;
    count_nxt    = count_r;
    pend_vld_nxt = 1'b0;
    pend_idx_nxt = pend_idx_r;
    pt_nxt       = pt_r;
    res_idx_nxt  = res_idx_r;
    res_new_nxt  = res_new_r;
    res_full_nxt = res_full_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          pt_nxt    = '{x: in_coord_x, y: in_coord_y, z: in_coord_z};
          issue_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          issue_nxt    = issue_r + 1'b1;
          pend_vld_nxt = !match;
          pend_idx_nxt = issue_r[AW-1:0];
        end
        if (match) begin
          res_idx_nxt  = IDX_W'(pend_idx_r);
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          state_nxt    = S_POST;
        end else if (miss_end) begin
          if (store_full) begin
            res_idx_nxt  = '0;
            res_new_nxt  = 1'b0;
            res_full_nxt = 1'b1;
          end else begin
            res_idx_nxt  = IDX_W'(count_r);
            res_new_nxt  = 1'b1;
            res_full_nxt = 1'b0;
            count_nxt    = count_r + 1'b1;
          end
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load the result, drop it on transfer
  always_comb begin
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_idx_nxt   = res_idx_r;
      out_new_nxt   = res_new_r;
      out_full_nxt  = res_full_r;
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= '0;
      count_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      count_r     <= count_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    pt_r       <= pt_nxt;
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    out_idx_r  <= out_idx_nxt;
    out_new_r  <= out_new_nxt;
    out_full_r <= out_full_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_point_index = out_idx_r;
  assign out_is_new      = out_new_r;
  assign out_table_full  = out_full_r;
  assign point_count     = count_r;

endmodule

[test/vertex_weld_table_unit_tb.sv]
module vertex_weld_table_unit_tb;
  import vwt_pkg::*;

  // Full-size store, same depth as the default build
  localparam int NUM_POINTS     = MAX_POINTS_DEF;
  localparam int WATCHDOG_LIMIT = 8 * (NUM_POINTS + 40);

  localparam logic [APB_AW-1:0] TOL_ADDR   = {REG_TOL, 2'b00};
  localparam logic [APB_AW-1:0] SPARE_ADDR = {~REG_TOL, 2'b00};

  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [IDX_W-1:0] point_index;
    logic             is_new;
    logic             table_full;
  } weld_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic signed [COORD_W-1:0] in_coord_z = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] out_point_index;
  logic             out_is_new;
  logic             out_table_full;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Shadow copy of the weld table
  logic signed [COORD_W-1:0] shadow_x [NUM_POINTS];
  logic signed [COORD_W-1:0] shadow_y [NUM_POINTS];
  logic signed [COORD_W-1:0] shadow_z [NUM_POINTS];
  int                        shadow_count = 0;
  logic [TOL_W-1:0]          weld_tol     = TOL_RESET;

  point_t       pending_points [$];
  point_t       point_history  [$];
  weld_result_t expected_welds [$];
  point_t       next_point;
  weld_result_t want;

  int errors      = 0;
  int send_gap    = 0;
  int hold_gap    = 0;
  int quiet_count = 0;
  bit idle_on     = 1'b0;

  vertex_weld_table_unit #(
    .MAX_POINTS(NUM_POINTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_index(out_point_index),
    .out_is_new     (out_is_new),
    .out_table_full (out_table_full),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Exact per-axis distance test, no wrap
  function automatic bit axis_near(logic signed [COORD_W-1:0] a,
                                   logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d < longint'(weld_tol);
  endfunction

  // Search the shadow table, append on a miss, drop when full
  function automatic weld_result_t weld_point(point_t p);
    weld_result_t r;
    bit           found;
    r     = '0;
    found = 1'b0;
    for (int i = 0; i < shadow_count && !found; i++) begin
      if (axis_near(p.x, shadow_x[i]) && axis_near(p.y, shadow_y[i]) &&
          axis_near(p.z, shadow_z[i])) begin
        r.point_index = IDX_W'(i);
        found         = 1'b1;
      end
    end
    if (!found) begin
      if (shadow_count >= NUM_POINTS) begin
        r.table_full = 1'b1;
      end else begin
        shadow_x[shadow_count] = p.x;
        shadow_y[shadow_count] = p.y;
        shadow_z[shadow_count] = p.z;
        r.point_index = IDX_W'(shadow_count);
        r.is_new      = 1'b1;
        shadow_count++;
      end
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] axis_offset(int unsigned reach);
    longint off;
    off = longint'($urandom_range(0, 2 * reach)) - longint'(reach);
    return off[COORD_W-1:0];
  endfunction

  function automatic point_t jitter_point(point_t base, int unsigned reach);
    point_t p;
    p.x = base.x + axis_offset(reach);
    p.y = base.y + axis_offset(reach);
    p.z = base.z + axis_offset(reach);
    return p;
  endfunction

  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(0, 3))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic queue_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
    point_t p;
    p = '{x: x, y: y, z: z};
    pending_points.push_back(p);
    point_history.push_back(p);
  endtask

  // Mostly near copies of earlier points, some on the exact border, some noise
  task automatic queue_random(int count);
    point_t       p;
    point_t       base;
    int unsigned  mode;
    int unsigned  reach;
    logic [31:0]  bump;
    @(negedge clk);
    for (int n = 0; n < count; n++) begin
      mode  = $urandom_range(0, 9);
      reach = (weld_tol == 0) ? 0 : weld_tol - 1;
      base  = point_history[$urandom_range(0, point_history.size() - 1)];
      if (mode < 5) begin
        p = jitter_point(base, reach);
      end else if (mode < 7) begin
        p    = jitter_point(base, reach);
        bump = $urandom_range(0, 1) ? 32'(weld_tol) : -32'(weld_tol);
        case ($urandom_range(0, 2))
          0:       p.x = base.x + bump;
          1:       p.y = base.y + bump;
          default: p.z = base.z + bump;
        endcase
      end else if (mode < 9) begin
        p = '{x: $urandom, y: $urandom, z: $urandom};
      end else begin
        p = '{x: extreme_coord(), y: extreme_coord(), z: extreme_coord()};
      end
      queue_point(p.x, p.y, p.z);
    end
  endtask

  // Hold until every queued point is sent and every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_points.size() != 0 || in_valid || expected_welds.size() != 0);
  endtask

  task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == TOL_ADDR) weld_tol = value[TOL_W-1:0];
  endtask

  task automatic check_tolerance();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TOL_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata[TOL_W-1:0] !== weld_tol) begin
      $display("%0t: tolerance readback expected %0d got %0d", $time, weld_tol,
               prdata[TOL_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: predict each transfer, then present the next point
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_welds.push_back(weld_point('{x: in_coord_x, y: in_coord_y, z: in_coord_z}));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_points.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else begin
          next_point = pending_points.pop_front();
          in_valid   <= 1'b1;
          in_coord_x <= next_point.x;
          in_coord_y <= next_point.y;
          in_coord_z <= next_point.z;
        end
      end
    end
  end

  // Monitor: compare each result transfer, stall in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_welds.size() == 0) begin
          $display("%0t: unexpected result, expected none got index %0d", $time,
                   out_point_index);
          errors++;
        end else begin
          want = expected_welds.pop_front();
          if (out_point_index !== want.point_index) begin
            $display("%0t: point_index expected %0d got %0d", $time, want.point_index,
                     out_point_index);
            errors++;
          end
          if (out_is_new !== want.is_new) begin
            $display("%0t: is_new expected %0b got %0b", $time, want.is_new, out_is_new);
            errors++;
          end
          if (out_table_full !== want.table_full) begin
            $display("%0t: table_full expected %0b got %0b", $time, want.table_full,
                     out_table_full);
            errors++;
          end
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold_gap = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
        if (quiet_count >= WATCHDOG_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, quiet_count);
          $display("vertex_weld_table_unit_tb NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [APB_DW-1:0] tol_plan [6];
    int                plan_count [6];
    tol_plan   = '{32'd1048576, 32'($urandom_range(1, 1048576)), 32'hFFE0_0003, 32'd0,
                   32'($urandom_range(16, 4096)), 32'd10};
    plan_count = '{110, 100, 90, 20, 100, 120};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    check_tolerance();

    // Reset tolerance: exact border, first match in order, coordinate extremes
    @(negedge clk);
    queue_point(0, 0, 0);
    queue_point(9, -9, 9);
    queue_point(10, 0, 0);
    queue_point(0, 0, -10);
    queue_point(8, 0, -5);
    queue_point(C_MIN, C_MIN, C_MIN);
    queue_point(C_MAX, C_MAX, C_MAX);
    queue_point(C_MAX, C_MIN, C_MAX);
    queue_point(C_MIN, C_MAX, C_MIN);
    queue_point(C_MIN + 9, C_MIN, C_MIN + 3);
    queue_point(C_MAX - 9, C_MAX - 1, C_MAX);
    queue_point(C_MAX, C_MIN, C_MIN);
    queue_point(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
    queue_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
    queue_point(-1, -1, -1);
    wait_drained();

    // Address past the register list must leave the tolerance alone
    write_reg(SPARE_ADDR, $urandom);
    check_tolerance();

    // Zero tolerance: exact duplicates still append
    write_reg(TOL_ADDR, 32'd0);
    check_tolerance();
    @(negedge clk);
    queue_point(0, 0, 0);
    queue_point(C_MAX, C_MAX, C_MAX);
    wait_drained();

    // Oversized write keeps only the low bits
    write_reg(TOL_ADDR, 32'hFFFF_FFFF);
    check_tolerance();
    @(negedge clk);
    queue_point(32'sh001F_FFFE, 0, 0);
    queue_point(32'sh001F_FFFF, 0, 0);
    queue_point(C_MAX - 32'sh001F_FFFE, C_MAX, C_MAX);
    queue_point(32'sh4000_0000, 32'sh4000_0000, -32'sh4000_0000);
    wait_drained();

    // Random phases, one tolerance each; last one runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(TOL_ADDR, tol_plan[ph]);
      check_tolerance();
      @(negedge clk);
      idle_on = (ph != 5);
      if (ph == 1) begin
        queue_random(plan_count[ph] / 2);
        wait_drained();
        queue_random(plan_count[ph] - plan_count[ph] / 2);
      end else begin
        queue_random(plan_count[ph]);
      end
      wait_drained();
    end

    repeat (NUM_POINTS + 8) @(posedge clk);
    if (errors == 0 && expected_welds.size() == 0) begin
      $display("vertex_weld_table_unit_tb OK");
    end else begin
      $display("vertex_weld_table_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
